[rtl/dtd_pkg.sv]
// ---------------------------------------------------------------------------
// dtd_pkg: shared types and tables for the date-time difference block
// Item layout between front end, queue and back end; month tables.
// ---------------------------------------------------------------------------
package dtd_pkg;

   localparam int DAY_W  = 21;  // days since 0001-01-01, up to 1460969
   localparam int HOUR_W = 26;

   // Status bits
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FIRST_BAD = 2'd1;
   localparam logic [1:0] STATUS_SECOND_BAD = 2'd2;

   // One date-time after classification
   typedef struct packed {
      logic [11:0] p;        // year - 1
      logic [5:0]  q100;     // (year - 1) / 100
      logic        leap;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } dt_fields_type;

   typedef struct packed {
      logic [1:0]    status;
      dt_fields_type a;
      dt_fields_type b;
   } dtd_item_type;

   function automatic logic [4:0] month_len(input logic [3:0] m);
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    month_len = 5'd30;
         4'd2:                                        month_len = 5'd28;
         default:                                     month_len = 5'd0;
      endcase
   endfunction

   // Days in the months before month m of a common year
   function automatic logic [8:0] days_before(input logic [3:0] m);
      case (m)
         4'd1:    days_before = 9'd0;
         4'd2:    days_before = 9'd31;
         4'd3:    days_before = 9'd59;
         4'd4:    days_before = 9'd90;
         4'd5:    days_before = 9'd120;
         4'd6:    days_before = 9'd151;
         4'd7:    days_before = 9'd181;
         4'd8:    days_before = 9'd212;
         4'd9:    days_before = 9'd243;
         4'd10:   days_before = 9'd273;
         4'd11:   days_before = 9'd304;
         4'd12:   days_before = 9'd334;
         default: days_before = 9'd0;
      endcase
   endfunction

endpackage

[rtl/datetime_difference.sv]
// ---------------------------------------------------------------------------
// datetime_difference: absolute difference of two Gregorian date-times
// Checks both date-times and returns the difference in hours, minutes and
// seconds, with a status code for invalid inputs.
// ---------------------------------------------------------------------------
//  channel   dir  tdata                          tuser
//  req_      in   two date-times, 76 of 80 bits  -
//  rsp_      out  hours, minutes, seconds        status
//
//  One transaction per cycle while the queue has room; after acceptance a
//  result passes queue write, day count, subtract and hours total in turn.
//  The queue of QUEUE_DEPTH entries absorbs back-end stalls; req_tready falls
//  only when it is full. The back end advances as a unit when the result
//  register is empty or being taken.
//  Synchronous reset clears the queue and all valid flags.
// ---------------------------------------------------------------------------
module datetime_difference
   import dtd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // first_year, first_month, first_day, first_hour, first_minute, first_second,
   // second_year, second_month, second_day, second_hour, second_minute,
   // second_sec, zero pad
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // diff_hours, diff_minutes, diff_seconds, zero pad
   output logic [39:0] rsp_tdata,
   // status
   output logic [1:0]  rsp_tuser
);

   logic         push_valid;
   logic         push_ready;
   dtd_item_type push_item;
   logic         q_valid;
   logic         q_ready;
   dtd_item_type q_item;

   dtd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   dtd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_item   (push_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   dtd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[rtl/dtd_front.sv]
// ---------------------------------------------------------------------------
// dtd_front: input front end
// Takes a transaction, checks both date-times and derives the year terms
// (year - 1, century count, leap flag) that the back end needs.
// ---------------------------------------------------------------------------
module dtd_front
   import dtd_pkg::*;
(
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,
   output logic         push_valid,
   output dtd_item_type push_item,
   input  logic         push_ready
);

   typedef struct packed {
      logic          ok;
      dt_fields_type f;
   } chk_type;

   function automatic chk_type classify(input logic [11:0] y, input logic [3:0] m,
                                        input logic [4:0] d, input logic [4:0] h,
                                        input logic [5:0] mi, input logic [5:0] s);
      logic [24:0] prod;
      logic [5:0]  qy;
      logic [12:0] back_mul;
      logic        cent;
      logic        leap;
      logic [4:0]  dim;
      chk_type     r;
      // y / 100 by reciprocal, exact for y < 4096
      prod     = 25'(y) * 25'd5243;
      qy       = prod[24:19];
      back_mul = 13'(qy) * 13'd100;
      cent     = (back_mul == {1'b0, y});
      leap     = ((y[1:0] == 2'd0) && !cent) || (cent && (qy[1:0] == 2'd0));
      dim      = ((m == 4'd2) && leap) ? 5'd29 : month_len(m);
      r.ok     = (y != 12'd0) && (y <= 12'd4000) && (m != 4'd0) && (m <= 4'd12) &&
                 (d != 5'd0) && (d <= dim) && (h <= 5'd23) && (mi <= 6'd59) &&
                 (s <= 6'd59);
      r.f.p      = y - 12'd1;
      r.f.q100   = qy - 6'(cent);   // floor((y-1)/100)
      r.f.leap   = leap;
      r.f.month  = m;
      r.f.day    = d;
      r.f.hour   = h;
      r.f.minute = mi;
      r.f.second = s;
      return r;
   endfunction

   chk_type chk_a;
   chk_type chk_b;

   always_comb begin
      chk_a = classify(req_tdata[11:0], req_tdata[15:12], req_tdata[20:16],
                       req_tdata[25:21], req_tdata[31:26], req_tdata[37:32]);
      chk_b = classify(req_tdata[49:38], req_tdata[53:50], req_tdata[58:54],
                       req_tdata[63:59], req_tdata[69:64], req_tdata[75:70]);
   end

   always_comb begin
      push_item.status = STATUS_OK;
      if (!chk_a.ok) begin
         push_item.status = push_item.status | STATUS_FIRST_BAD;
      end
      if (!chk_b.ok) begin
         push_item.status = push_item.status | STATUS_SECOND_BAD;
      end
      push_item.a = chk_a.f;
      push_item.b = chk_b.f;
   end

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;

endmodule

[rtl/dtd_queue.sv]
// ---------------------------------------------------------------------------
// dtd_queue: small FIFO between front end and back end
// Register-based, first-word fall-through.
// ---------------------------------------------------------------------------
module dtd_queue
   import dtd_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  dtd_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output dtd_item_type out_item
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   dtd_item_type       mem_ff [DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               push;
   logic               pop;

   assign in_ready  = (count_ff != CW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count past depth");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("queue count did not follow a write");
`endif

endmodule

[rtl/dtd_back.sv]
// ---------------------------------------------------------------------------
// dtd_back: arithmetic back end
// Day count per date-time, ordered subtraction with borrows through
// seconds, minutes, hours and days, then hours total into the result register.
// ---------------------------------------------------------------------------
module dtd_back
   import dtd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   output logic         q_ready,
   input  dtd_item_type q_item,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,   // diff_hours[25:0], diff_minutes, diff_seconds, zero pad
   output logic [1:0]   rsp_tuser    // status
);

   typedef struct packed {
      logic [DAY_W-1:0] days;
      logic [4:0]       hour;
      logic [5:0]       minute;
      logic [5:0]       second;
   } stamp_type;

   function automatic stamp_type to_stamp(input dt_fields_type f);
      logic [DAY_W-1:0] dy;
      stamp_type        r;
      dy = DAY_W'(f.p) * DAY_W'(365) + DAY_W'(f.p[11:2]) - DAY_W'(f.q100)
         + DAY_W'(f.q100[5:2]) + DAY_W'(days_before(f.month))
         + DAY_W'(f.leap && (f.month > 4'd2)) + DAY_W'(f.day) - DAY_W'(1);
      r.days   = dy;
      r.hour   = f.hour;
      r.minute = f.minute;
      r.second = f.second;
      return r;
   endfunction

   logic             adv;
   // stage 1
   logic             s1_valid_ff;
   logic [1:0]       s1_status_ff;
   stamp_type        s1_a_ff, s1_a_in;
   stamp_type        s1_b_ff, s1_b_in;
   // stage 2
   logic             s2_valid_ff;
   logic [1:0]       s2_status_ff;
   logic [DAY_W-1:0] s2_dd_ff, s2_dd_in;
   logic [4:0]       s2_dh_ff, s2_dh_in;
   logic [5:0]       s2_dm_ff, s2_dm_in;
   logic [5:0]       s2_ds_ff, s2_ds_in;
   // result register
   logic             rsp_valid_ff;
   logic [1:0]       rsp_status_ff;
   logic [HOUR_W-1:0] rsp_hours_ff, rsp_hours_in;
   logic [5:0]       rsp_minutes_ff, rsp_minutes_in;
   logic [5:0]       rsp_seconds_ff, rsp_seconds_in;

   stamp_type        hi;
   stamp_type        lo;
   logic [6:0]       sec_raw;
   logic [6:0]       min_raw;
   logic [5:0]       hr_raw;

   // whole pipeline moves when the result register is free
   assign adv     = !rsp_valid_ff || rsp_tready;
   assign q_ready = adv;

   always_comb begin
      s1_a_in = to_stamp(q_item.a);
      s1_b_in = to_stamp(q_item.b);
   end

   // fields are range-checked, so the packed stamp orders like total seconds
   always_comb begin
      if (s1_a_ff >= s1_b_ff) begin
         hi = s1_a_ff;
         lo = s1_b_ff;
      end else begin
         hi = s1_b_ff;
         lo = s1_a_ff;
      end
      sec_raw  = 7'(hi.second) - 7'(lo.second);
      s2_ds_in = sec_raw[6] ? 6'(sec_raw + 7'd60) : sec_raw[5:0];
      min_raw  = 7'(hi.minute) - 7'(lo.minute) - 7'(sec_raw[6]);
      s2_dm_in = min_raw[6] ? 6'(min_raw + 7'd60) : min_raw[5:0];
      hr_raw   = 6'(hi.hour) - 6'(lo.hour) - 6'(min_raw[6]);
      s2_dh_in = hr_raw[5] ? 5'(hr_raw + 6'd24) : hr_raw[4:0];
      s2_dd_in = hi.days - lo.days - DAY_W'(hr_raw[5]);
   end

   always_comb begin
      rsp_hours_in   = '0;
      rsp_minutes_in = '0;
      rsp_seconds_in = '0;
      if (s2_status_ff == STATUS_OK) begin
         rsp_hours_in   = HOUR_W'({s2_dd_ff, 4'b0000}) + HOUR_W'({s2_dd_ff, 3'b000})
                        + HOUR_W'(s2_dh_ff);
         rsp_minutes_in = s2_dm_ff;
         rsp_seconds_in = s2_ds_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= q_valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_status_ff   <= q_item.status;
         s1_a_ff        <= s1_a_in;
         s1_b_ff        <= s1_b_in;
         s2_status_ff   <= s1_status_ff;
         s2_dd_ff       <= s2_dd_in;
         s2_dh_ff       <= s2_dh_in;
         s2_dm_ff       <= s2_dm_in;
         s2_ds_ff       <= s2_ds_in;
         rsp_status_ff  <= s2_status_ff;
         rsp_hours_ff   <= rsp_hours_in;
         rsp_minutes_ff <= rsp_minutes_in;
         rsp_seconds_ff <= rsp_seconds_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_seconds_ff, rsp_minutes_ff, rsp_hours_ff};

`ifndef SYNTHESIS
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STATUS_OK)) |->
         ((rsp_hours_ff == '0) && (rsp_minutes_ff == '0) && (rsp_seconds_ff == '0)))
      else $error("nonzero difference with invalid date-time");
   a_sexagesimal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_minutes_ff < 6'd60) && (rsp_seconds_ff < 6'd60)))
      else $error("minutes or seconds out of range");
`endif

endmodule
